FILE: design/fat16_cluster_chain_walker_unit_assert.svh
// Assertion macros for the cluster chain walker.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef FAT16_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCW_ASSERT_NOW(label, ante, cons, msg)
`define FCW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/fcw_pkg.sv
package fcw_pkg;

    typedef enum logic [1:0] {
        KIND_RUN    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_FAIL   = 2'd3
    } kind_t;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WORD  = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;

    localparam logic [1:0] CFG_DATA_START  = 2'd0;
    localparam logic [1:0] CFG_SEC_PER_CL  = 2'd1;
    localparam logic [1:0] CFG_FAT_START   = 2'd2;
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd3;

    localparam logic [15:0] END_MARK     = 16'hFFF8;
    localparam logic [31:0] CLUSTER_BASE = 32'd2;

    typedef struct packed {
        logic  capture;
        logic  load_start;
        logic  load_word;
        logic  clear_tag;
        logic  advance;
        logic  set_tag;
        logic  emit;
        kind_t emit_kind;
        logic  emit_total;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       budget_zero;
        logic       word_end;
        logic       owed_zero;
        logic       out_of_range;
    } sts_t;

endpackage

FILE: design/fcw_ctrl.sv
module fcw_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  fcw_pkg::sts_t sts,
    output fcw_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CALC,
        S_RUN,
        S_LOOKUP
    } state_t;

    typedef enum logic {
        PH_IDLE,
        PH_WAIT
    } phase_t;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (sts.opcode)
                    fcw_pkg::OP_START:
                    begin
                        cmd.load_start = 1'b1;
                        if (sts.budget_zero)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = fcw_pkg::KIND_DONE;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            state_next = S_CALC;
                        end
                    end
                    fcw_pkg::OP_WORD:
                    begin
                        if (phase_reg == PH_WAIT)
                        begin
                            if (sts.word_end || sts.owed_zero)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_kind  = fcw_pkg::KIND_DONE;
                                cmd.emit_total = 1'b1;
                                phase_next     = PH_IDLE;
                            end
                            else
                            begin
                                cmd.load_word = 1'b1;
                                state_next    = S_CALC;
                            end
                        end
                    end
                    fcw_pkg::OP_FAIL:
                    begin
                        cmd.clear_tag = 1'b1;
                        if (phase_reg == PH_WAIT)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = fcw_pkg::KIND_FAIL;
                            phase_next    = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CALC:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = fcw_pkg::KIND_RUN;
                cmd.advance   = 1'b1;
                state_next    = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (sts.out_of_range)
                begin
                    cmd.emit_kind = fcw_pkg::KIND_FAIL;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    cmd.emit_kind = fcw_pkg::KIND_LOOKUP;
                    cmd.set_tag   = 1'b1;
                    phase_next    = PH_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/fcw_datapath.sv
module fcw_datapath #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fcw_pkg::cmd_t cmd,
    output fcw_pkg::sts_t sts,
    input  logic [1:0]    opcode,
    input  logic [15:0]   start_cluster,
    input  logic [30:0]   size_bytes,
    input  logic [15:0]   table_word,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    output logic          result_valid,
    output logic [1:0]    kind,
    output logic [31:0]   sector,
    output logic [7:0]    sector_count,
    output logic [7:0]    word_index,
    output logic          fetch_needed,
    output logic [31:0]   byte_offset,
    output logic          last
);

    localparam int SectorShift = $clog2(SECTOR_BYTES);
    localparam logic [15:0] WordMask = 16'(SECTOR_BYTES / 2 - 1);

    logic [30:0] data_start_reg;
    logic [7:0]  spc_reg;
    logic [30:0] fat_start_reg;
    logic [23:0] entry_count_reg;

    logic [1:0]  op_reg;
    logic [15:0] first_reg;
    logic [30:0] size_reg;
    logic [15:0] word_reg;

    logic [15:0] cluster_reg;
    logic [15:0] cluster_next;
    logic [23:0] owed_reg;
    logic [23:0] owed_next;
    logic [22:0] loaded_reg;
    logic [22:0] loaded_next;
    logic [31:0] cached_reg;
    logic [31:0] cached_next;
    logic        tag_valid_reg;
    logic        tag_valid_next;

    logic [31:0] run_prod_reg;
    logic [30:0] tot_prod_reg;

    logic        strobe_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [31:0] sector_reg;
    logic [31:0] sector_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [7:0]  widx_reg;
    logic [7:0]  widx_next;
    logic        fetch_reg;
    logic        fetch_next;
    logic [31:0] offset_reg;
    logic [31:0] offset_next;
    logic        last_reg;
    logic        last_next;

    logic [23:0] budget;
    logic [31:0] cl_minus_base;
    logic [31:0] run_full;
    logic [7:0]  run_count;
    logic [31:0] total_bytes;
    logic [31:0] table_sector;
    logic [7:0]  table_index;
    logic        table_fetch;

    assign budget        = 24'(size_reg >> SectorShift);
    assign cl_minus_base = {16'd0, cluster_reg} - fcw_pkg::CLUSTER_BASE;
    assign run_full      = cl_minus_base * {24'd0, spc_reg};
    assign run_count     = (owed_reg < {16'd0, spc_reg}) ? owed_reg[7:0] : spc_reg;
    assign total_bytes   = 32'({1'b0, tot_prod_reg} << SectorShift);
    assign table_sector  = {1'b0, fat_start_reg} + 32'(cluster_reg >> (SectorShift - 1));
    assign table_index   = 8'(cluster_reg & WordMask);
    assign table_fetch   = !tag_valid_reg || (table_sector != cached_reg);

    assign sts.opcode       = op_reg;
    assign sts.budget_zero  = (budget == 24'd0);
    assign sts.word_end     = (word_reg >= fcw_pkg::END_MARK);
    assign sts.owed_zero    = (owed_reg == 24'd0);
    assign sts.out_of_range = ({8'd0, cluster_reg} >= entry_count_reg);

    always_comb
    begin
        cluster_next   = cluster_reg;
        owed_next      = owed_reg;
        loaded_next    = loaded_reg;
        cached_next    = cached_reg;
        tag_valid_next = tag_valid_reg;
        if (cmd.load_start)
        begin
            cluster_next = first_reg;
            owed_next    = budget;
            loaded_next  = '0;
        end
        if (cmd.load_word)
        begin
            cluster_next = word_reg;
        end
        if (cmd.advance)
        begin
            owed_next   = owed_reg - {16'd0, run_count};
            loaded_next = loaded_reg + 23'd1;
        end
        if (cmd.set_tag)
        begin
            cached_next    = table_sector;
            tag_valid_next = 1'b1;
        end
        if (cmd.clear_tag)
        begin
            tag_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        kind_next   = cmd.emit_kind;
        sector_next = '0;
        count_next  = '0;
        widx_next   = '0;
        fetch_next  = 1'b0;
        offset_next = '0;
        last_next   = 1'b1;
        case (cmd.emit_kind)
            fcw_pkg::KIND_RUN:
            begin
                sector_next = {1'b0, data_start_reg} + run_prod_reg;
                count_next  = run_count;
                offset_next = total_bytes;
                last_next   = 1'b0;
            end
            fcw_pkg::KIND_LOOKUP:
            begin
                sector_next = table_sector;
                widx_next   = table_index;
                fetch_next  = table_fetch;
            end
            fcw_pkg::KIND_DONE:
            begin
                offset_next = cmd.emit_total ? total_bytes : 32'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg  <= '0;
            spc_reg         <= 8'd1;
            fat_start_reg   <= '0;
            entry_count_reg <= '0;
            cluster_reg     <= '0;
            owed_reg        <= '0;
            loaded_reg      <= '0;
            cached_reg      <= '0;
            tag_valid_reg   <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fcw_pkg::CFG_DATA_START:  data_start_reg  <= cfg_data;
                    fcw_pkg::CFG_SEC_PER_CL:  spc_reg         <= cfg_data[7:0];
                    fcw_pkg::CFG_FAT_START:   fat_start_reg   <= cfg_data;
                    fcw_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[23:0];
                    default:
                    begin
                    end
                endcase
            end
            cluster_reg   <= cluster_next;
            owed_reg      <= owed_next;
            loaded_reg    <= loaded_next;
            cached_reg    <= cached_next;
            tag_valid_reg <= tag_valid_next;
            strobe_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            first_reg <= start_cluster;
            size_reg  <= size_bytes;
            word_reg  <= table_word;
        end
        run_prod_reg <= run_full;
        tot_prod_reg <= 31'(loaded_reg * spc_reg);
        if (cmd.emit)
        begin
            kind_reg   <= kind_next;
            sector_reg <= sector_next;
            count_reg  <= count_next;
            widx_reg   <= widx_next;
            fetch_reg  <= fetch_next;
            offset_reg <= offset_next;
            last_reg   <= last_next;
        end
    end

    assign result_valid = strobe_reg;
    assign kind         = kind_reg;
    assign sector       = sector_reg;
    assign sector_count = count_reg;
    assign word_index   = widx_reg;
    assign fetch_needed = fetch_reg;
    assign byte_offset  = offset_reg;
    assign last         = last_reg;

endmodule

FILE: design/fat16_cluster_chain_walker_unit.sv
// Cluster chain walker for a FAT16 volume.
// Configuration is written over the cfg_valid/cfg_ready channel; the user must write it only
// while the block is idle, as the block does not enforce this. cfg_index selects data start
// sector, sectors per cluster, table start sector or table entry count. cfg_ready is always high.
// An item is a transaction on the command channel: it is taken at a clock edge with start
// high and busy low. Opcode start begins a walk, opcode table word answers the last lookup,
// and opcode read failure aborts the walk and drops the cached table sector.
// Each result is shown for exactly one cycle with result_valid high; the receiver
// cannot stall the block, so it must take every result as it appears.
// A start or table word that continues the walk is busy through a decode state, a state
// for the cluster products, then a state that issues the run read and one that issues the lookup
// (or failure); each result is registered before it appears on the result ports.
// Items with a single result are busy only in the decode state and show it in the cycle after.
// So a new item is taken only after busy falls again, at the end of the decode state or,
// for a walk that continues, of the lookup state of the controller sequence.
// Reset clears the walk, the cache tag and the configuration to their default values.
`include "fat16_cluster_chain_walker_unit_assert.svh"

module fat16_cluster_chain_walker_unit #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] start_cluster,
    input  logic [30:0] size_bytes,
    input  logic [15:0] table_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [31:0] sector,
    output logic [7:0]  sector_count,
    output logic [7:0]  word_index,
    output logic        fetch_needed,
    output logic [31:0] byte_offset,
    output logic        last
);

    fcw_pkg::cmd_t cmd;
    fcw_pkg::sts_t sts;
    logic          run_shown;
    logic          tail_shown;

    assign cfg_ready = 1'b1;

    fcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fcw_datapath #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .start_cluster(start_cluster),
        .size_bytes   (size_bytes),
        .table_word   (table_word),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .kind         (kind),
        .sector       (sector),
        .sector_count (sector_count),
        .word_index   (word_index),
        .fetch_needed (fetch_needed),
        .byte_offset  (byte_offset),
        .last         (last)
    );

    assign run_shown  = result_valid && (kind == fcw_pkg::KIND_RUN);
    assign tail_shown = result_valid
                        && ((kind == fcw_pkg::KIND_LOOKUP) || (kind == fcw_pkg::KIND_FAIL));

    `FCW_ASSERT_NEXT(a_accept_quiet, start && !busy, !result_valid, "result right after accept")
    `FCW_ASSERT_NEXT(a_last_gap, result_valid && last, !result_valid, "result after last")
    `FCW_ASSERT_NEXT(a_run_pair, run_shown, tail_shown, "run read not followed by lookup")
    `FCW_ASSERT_NOW(a_run_not_last, run_shown, !last, "run read marked last")

endmodule
